### design/multilevel_feedback_queue_scheduler_macros.svh
// Assertion macros for the multilevel feedback queue scheduler.
// Used by the top level only; each macro expects clk and rst_n in scope.
`ifndef MULTILEVEL_FEEDBACK_QUEUE_SCHEDULER_MACROS_SVH
`define MULTILEVEL_FEEDBACK_QUEUE_SCHEDULER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MLFQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MLFQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/mlfq_pkg.sv
// Shared types and constants of the multilevel feedback queue scheduler.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package mlfq_pkg;

  localparam int LEVELS              = 3;
  localparam int TASKS_DEFAULT       = 16;
  localparam int QUEUE_DEPTH_DEFAULT = 16;

  localparam int ID_W    = 4;
  localparam int BURST_W = 8;
  localparam int QUANT_W = 8;
  localparam int TIME_W  = 16;
  localparam int LVL_W   = 2;
  localparam int CFG_W   = 2;

  localparam logic [QUANT_W-1:0] QUANTUM0_RESET = 8'd1;
  localparam logic [QUANT_W-1:0] QUANTUM1_RESET = 8'd2;
  localparam logic [QUANT_W-1:0] QUANTUM2_RESET = 8'd4;

  localparam logic OP_ARRIVE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  localparam logic KIND_ARRIVE = 1'b0;
  localparam logic KIND_TICK   = 1'b1;

  localparam logic [CFG_W-1:0] CFG_QUANTUM0 = 2'd0;
  localparam logic [CFG_W-1:0] CFG_QUANTUM1 = 2'd1;
  localparam logic [CFG_W-1:0] CFG_QUANTUM2 = 2'd2;

  localparam logic [LVL_W-1:0] LVL_TOP    = 2'd0;
  localparam logic [LVL_W-1:0] LVL_MIDDLE = 2'd1;
  localparam logic [LVL_W-1:0] LVL_BOTTOM = 2'd2;

  typedef struct packed {
    logic               opcode;
    logic [ID_W-1:0]    task_id;
    logic [BURST_W-1:0] task_burst;
  } in_item_t;

  typedef struct packed {
    logic              result_kind;
    logic              accepted;
    logic              run_valid;
    logic [ID_W-1:0]   run_id;
    logic [TIME_W-1:0] now_time;
    logic              done_valid;
    logic [ID_W-1:0]   done_id;
  } out_item_t;

  // One task record as held in the task table.
  typedef struct packed {
    logic [BURST_W-1:0] burst;
    logic [BURST_W-1:0] served;
    logic [LVL_W-1:0]   level;
  } task_rec_t;

  // Per-field write enables of the task table.
  typedef struct packed {
    logic burst;
    logic served;
    logic level;
  } tbl_we_t;

  // Result of the shared saturating increment and compare unit.
  typedef struct packed {
    logic [BURST_W-1:0] sum;
    logic               ge;
  } alu_res_t;

endpackage

### design/mlfq_alu.sv
// Shared saturating increment and compare unit of the scheduler.
// Depends on mlfq_pkg.
`timescale 1ns / 1ps

module mlfq_alu (
  input  logic [mlfq_pkg::BURST_W-1:0] a,
  input  logic [mlfq_pkg::BURST_W-1:0] b,
  output mlfq_pkg::alu_res_t           res
);
  import mlfq_pkg::*;

  logic [BURST_W-1:0] sum;

  // The counter sticks at its top value rather than wrapping.
  assign sum     = (a == {BURST_W{1'b1}}) ? a : a + 1'b1;
  assign res.sum = sum;
  assign res.ge  = (sum >= b);

endmodule

### design/mlfq_task_table.sv
// Per-task table of burst length, served time and level, with registered read.
// Depends on mlfq_pkg.
`timescale 1ns / 1ps

module mlfq_task_table #(
  parameter int  TASKS = mlfq_pkg::TASKS_DEFAULT,
  localparam int IDX_W = $clog2(TASKS)
) (
  input  logic                 clk,
  input  mlfq_pkg::tbl_we_t    we,
  input  logic [IDX_W-1:0]     wr_addr,
  input  mlfq_pkg::task_rec_t  wr_data,
  input  logic [IDX_W-1:0]     rd_addr,
  output mlfq_pkg::task_rec_t  rd_data
);
  import mlfq_pkg::*;

  logic [BURST_W-1:0] burst_mem  [TASKS];
  logic [BURST_W-1:0] served_mem [TASKS];
  logic [LVL_W-1:0]   level_mem  [TASKS];

  always_ff @(posedge clk) begin
    if (we.burst) begin
      burst_mem[wr_addr] <= wr_data.burst;
    end
    if (we.served) begin
      served_mem[wr_addr] <= wr_data.served;
    end
    if (we.level) begin
      level_mem[wr_addr] <= wr_data.level;
    end
    rd_data.burst  <= burst_mem[rd_addr];
    rd_data.served <= served_mem[rd_addr];
    rd_data.level  <= level_mem[rd_addr];
  end

endmodule

### design/mlfq_queue_ram.sv
// Storage of the three level queues in one memory, one write and one read port.
// Depends on mlfq_pkg.
`timescale 1ns / 1ps

module mlfq_queue_ram #(
  parameter int  QUEUE_DEPTH = mlfq_pkg::QUEUE_DEPTH_DEFAULT,
  localparam int PTR_W       = $clog2(QUEUE_DEPTH)
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [mlfq_pkg::LVL_W-1:0]  wr_lvl,
  input  logic [PTR_W-1:0]            wr_ptr,
  input  logic [mlfq_pkg::ID_W-1:0]   wr_id,
  input  logic [mlfq_pkg::LVL_W-1:0]  rd_lvl,
  input  logic [PTR_W-1:0]            rd_ptr,
  output logic [mlfq_pkg::ID_W-1:0]   rd_id
);
  import mlfq_pkg::*;

  localparam int ENTRIES = LEVELS * QUEUE_DEPTH;
  localparam int AW      = $clog2(ENTRIES);

  logic [ID_W-1:0] mem [ENTRIES];
  logic [AW-1:0]   wr_addr;
  logic [AW-1:0]   rd_addr;

  // Each level owns a contiguous region of QUEUE_DEPTH entries.
  assign wr_addr = AW'(wr_lvl) * AW'(QUEUE_DEPTH) + AW'(wr_ptr);
  assign rd_addr = AW'(rd_lvl) * AW'(QUEUE_DEPTH) + AW'(rd_ptr);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_id;
    end
    rd_id <= mem[rd_addr];
  end

endmodule

### design/multilevel_feedback_queue_scheduler.sv
// Top level of the three-level feedback queue scheduler: sequencer and queue pointers.
// Depends on mlfq_pkg, mlfq_alu, mlfq_task_table, mlfq_queue_ram and the macro header.
`timescale 1ns / 1ps
`include "multilevel_feedback_queue_scheduler_macros.svh"

// The scheduler takes one transaction whenever start is high and busy is low, and
// answers every transaction with exactly one result, shown on out_data for a single
// cycle while out_valid is high; the receiver cannot stall, so the result must be
// captured in that cycle. An arrive transaction is handled in the cycle it is taken
// and its answer appears in the next cycle, while busy stays low, so arrivals may
// follow one another back to back. A tick transaction is worked through by a small
// sequencer that shares one saturating increment and compare unit: an idle tick is
// answered from the requeue and dispatch states, a tick that keeps the running task
// goes on through the charge and slice states, and a tick that dispatches a new task
// also passes the fetch and lookup states, the registered reads of the queue memory
// and of the task table. Busy is high from the cycle after a tick is accepted until
// its result is shown. The quantum registers are written through the cfg_ port, which
// is always ready; they should only be changed while no transaction is in progress.
module multilevel_feedback_queue_scheduler #(
  parameter int  TASKS       = mlfq_pkg::TASKS_DEFAULT,
  parameter int  QUEUE_DEPTH = mlfq_pkg::QUEUE_DEPTH_DEFAULT,
  localparam int IDX_W       = $clog2(TASKS),
  localparam int PTR_W       = $clog2(QUEUE_DEPTH),
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Input transactions
  input  logic                          start,
  output logic                          busy,
  input  mlfq_pkg::in_item_t            in_data,
  // Results
  output logic                          out_valid,
  output mlfq_pkg::out_item_t           out_data,
  // Configuration writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mlfq_pkg::CFG_W-1:0]    cfg_index,
  input  logic [mlfq_pkg::QUANT_W-1:0]  cfg_data
);
  import mlfq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_REQUEUE,
    S_DISPATCH,
    S_FETCH,
    S_LOOKUP,
    S_CHARGE,
    S_SLICE
  } state_t;

  state_t state_r, state_nxt;

  logic [QUANT_W-1:0] quantum0_r, quantum0_nxt;
  logic [QUANT_W-1:0] quantum1_r, quantum1_nxt;
  logic [QUANT_W-1:0] quantum2_r, quantum2_nxt;

  logic [PTR_W-1:0] head_r  [LEVELS];
  logic [PTR_W-1:0] head_nxt[LEVELS];
  logic [PTR_W-1:0] tail_r  [LEVELS];
  logic [PTR_W-1:0] tail_nxt[LEVELS];
  logic [CNT_W-1:0] count_r  [LEVELS];
  logic [CNT_W-1:0] count_nxt[LEVELS];

  logic [ID_W-1:0]    running_r, running_nxt;
  logic               cpu_busy_r, cpu_busy_nxt;
  logic               req_pend_r, req_pend_nxt;
  logic [QUANT_W-1:0] slice_r, slice_nxt;
  logic [TIME_W-1:0]  time_r, time_nxt;
  logic               done_r, done_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r, out_data_nxt;

  // Task table and queue memory connections.
  tbl_we_t          tbl_we;
  logic [IDX_W-1:0] tbl_wr_addr;
  task_rec_t        tbl_wr_data;
  task_rec_t        tbl_rd;
  logic             qram_wr_en;
  logic [ID_W-1:0]  qram_wr_id;
  logic [ID_W-1:0]  qram_rd_id;

  // Shared increment and compare unit.
  logic [BURST_W-1:0] alu_a;
  logic [BURST_W-1:0] alu_b;
  alu_res_t           alu_res;

  logic               any_nonempty;
  logic [LVL_W-1:0]   lvl_cur;
  logic [LVL_W-1:0]   req_lvl;
  logic [LVL_W-1:0]   disp_lvl;
  logic [LVL_W-1:0]   q_sel;
  logic [PTR_W-1:0]   sel_head;
  logic [PTR_W-1:0]   sel_tail;
  logic [CNT_W-1:0]   sel_cnt;
  logic               sel_not_full;
  logic               id_in_range;
  logic               arrive_ok;
  logic [QUANT_W-1:0] cur_quantum;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The table is always read at the running task; the read data is registered.
  mlfq_task_table #(
    .TASKS (TASKS)
  ) u_task_table (
    .clk     (clk),
    .we      (tbl_we),
    .wr_addr (tbl_wr_addr),
    .wr_data (tbl_wr_data),
    .rd_addr (IDX_W'(running_r)),
    .rd_data (tbl_rd)
  );

  mlfq_queue_ram #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue_ram (
    .clk    (clk),
    .wr_en  (qram_wr_en),
    .wr_lvl (q_sel),
    .wr_ptr (sel_tail),
    .wr_id  (qram_wr_id),
    .rd_lvl (q_sel),
    .rd_ptr (sel_head),
    .rd_id  (qram_rd_id)
  );

  mlfq_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res)
  );

  assign any_nonempty = (count_r[0] != '0) || (count_r[1] != '0) || (count_r[2] != '0);

  // A stored level of three cannot arise, but it is treated as the bottom level.
  assign lvl_cur = (tbl_rd.level > LVL_BOTTOM) ? LVL_BOTTOM : tbl_rd.level;

  // A preempted task only drops a level when some other work is waiting.
  assign req_lvl = (any_nonempty && (lvl_cur < LVL_BOTTOM)) ? lvl_cur + 1'b1 : lvl_cur;

  assign disp_lvl = (count_r[0] != '0) ? LVL_TOP :
                    (count_r[1] != '0) ? LVL_MIDDLE : LVL_BOTTOM;

  // One queue is addressed per cycle: level 0 for arrivals, the requeue level,
  // or the highest non-empty level when dispatching.
  always_comb begin
    case (state_r)
      S_REQUEUE:  q_sel = req_lvl;
      S_DISPATCH: q_sel = disp_lvl;
      default:    q_sel = LVL_TOP;
    endcase
  end

  assign sel_head     = head_r[q_sel];
  assign sel_tail     = tail_r[q_sel];
  assign sel_cnt      = count_r[q_sel];
  assign sel_not_full = (sel_cnt < CNT_W'(QUEUE_DEPTH));

  assign id_in_range = (32'(in_data.task_id) < TASKS);
  assign arrive_ok   = id_in_range && sel_not_full;

  always_comb begin
    case (lvl_cur)
      LVL_TOP:    cur_quantum = quantum0_r;
      LVL_MIDDLE: cur_quantum = quantum1_r;
      default:    cur_quantum = quantum2_r;
    endcase
  end

  // The unit charges served time against the burst, then the slice against the quantum.
  assign alu_a = (state_r == S_SLICE) ? slice_r : tbl_rd.served;
  assign alu_b = (state_r == S_SLICE) ? cur_quantum : tbl_rd.burst;

  // Task table writes: a whole record on arrival, the level on a requeue and
  // the served time when a tick is charged.
  always_comb begin
    tbl_we             = '0;
    tbl_wr_addr        = IDX_W'(running_r);
    tbl_wr_data.burst  = in_data.task_burst;
    tbl_wr_data.served = alu_res.sum;
    tbl_wr_data.level  = req_lvl;
    qram_wr_en         = 1'b0;
    qram_wr_id         = running_r;
    case (state_r)
      S_IDLE: begin
        tbl_wr_addr        = IDX_W'(in_data.task_id);
        tbl_wr_data.served = '0;
        tbl_wr_data.level  = LVL_TOP;
        qram_wr_id         = in_data.task_id;
        if (start && (in_data.opcode == OP_ARRIVE) && arrive_ok) begin
          tbl_we     = '{burst: 1'b1, served: 1'b1, level: 1'b1};
          qram_wr_en = 1'b1;
        end
      end
      S_REQUEUE: begin
        if (req_pend_r) begin
          tbl_we.level = 1'b1;
          qram_wr_en   = sel_not_full;
        end
      end
      S_CHARGE: begin
        tbl_we.served = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Sequencer and next-state logic of every register.
  always_comb begin
    state_nxt     = state_r;
    quantum0_nxt  = quantum0_r;
    quantum1_nxt  = quantum1_r;
    quantum2_nxt  = quantum2_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    running_nxt   = running_r;
    cpu_busy_nxt  = cpu_busy_r;
    req_pend_nxt  = req_pend_r;
    slice_nxt     = slice_r;
    time_nxt      = time_r;
    done_nxt      = done_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;

    if (cfg_valid) begin
      case (cfg_index)
        CFG_QUANTUM0: quantum0_nxt = cfg_data;
        CFG_QUANTUM1: quantum1_nxt = cfg_data;
        CFG_QUANTUM2: quantum2_nxt = cfg_data;
        default: begin
        end
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_data.opcode == OP_ARRIVE) begin
            if (arrive_ok) begin
              tail_nxt[LVL_TOP]  = ptr_inc(sel_tail);
              count_nxt[LVL_TOP] = sel_cnt + 1'b1;
            end
            out_valid_nxt            = 1'b1;
            out_data_nxt             = '0;
            out_data_nxt.result_kind = KIND_ARRIVE;
            out_data_nxt.accepted    = arrive_ok;
            out_data_nxt.now_time    = time_r;
          end else begin
            state_nxt = S_REQUEUE;
          end
        end
      end
      S_REQUEUE: begin
        if (req_pend_r) begin
          // A requeue into a full queue drops the task.
          if (sel_not_full) begin
            tail_nxt[q_sel]  = ptr_inc(sel_tail);
            count_nxt[q_sel] = sel_cnt + 1'b1;
          end
          cpu_busy_nxt = 1'b0;
          req_pend_nxt = 1'b0;
        end
        state_nxt = S_DISPATCH;
      end
      S_DISPATCH: begin
        if (cpu_busy_r) begin
          state_nxt = S_CHARGE;
        end else if (any_nonempty) begin
          head_nxt[q_sel]  = ptr_inc(sel_head);
          count_nxt[q_sel] = sel_cnt - 1'b1;
          cpu_busy_nxt     = 1'b1;
          slice_nxt        = '0;
          state_nxt        = S_FETCH;
        end else begin
          // Nothing to run: time still moves on.
          time_nxt                 = time_r + 1'b1;
          out_valid_nxt            = 1'b1;
          out_data_nxt             = '0;
          out_data_nxt.result_kind = KIND_TICK;
          out_data_nxt.now_time    = time_r + 1'b1;
          state_nxt                = S_IDLE;
        end
      end
      S_FETCH: begin
        running_nxt = qram_rd_id;
        state_nxt   = S_LOOKUP;
      end
      S_LOOKUP: begin
        state_nxt = S_CHARGE;
      end
      S_CHARGE: begin
        done_nxt  = alu_res.ge;
        state_nxt = S_SLICE;
      end
      S_SLICE: begin
        slice_nxt = alu_res.sum;
        time_nxt  = time_r + 1'b1;
        if (done_r) begin
          cpu_busy_nxt = 1'b0;
        end else if (alu_res.ge) begin
          req_pend_nxt = 1'b1;
          cpu_busy_nxt = 1'b0;
        end
        out_valid_nxt            = 1'b1;
        out_data_nxt             = '0;
        out_data_nxt.result_kind = KIND_TICK;
        out_data_nxt.run_valid   = 1'b1;
        out_data_nxt.run_id      = running_r;
        out_data_nxt.now_time    = time_r + 1'b1;
        out_data_nxt.done_valid  = done_r;
        out_data_nxt.done_id     = done_r ? running_r : '0;
        state_nxt                = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      quantum0_r  <= QUANTUM0_RESET;
      quantum1_r  <= QUANTUM1_RESET;
      quantum2_r  <= QUANTUM2_RESET;
      head_r      <= '{default: '0};
      tail_r      <= '{default: '0};
      count_r     <= '{default: '0};
      running_r   <= '0;
      cpu_busy_r  <= 1'b0;
      req_pend_r  <= 1'b0;
      slice_r     <= '0;
      time_r      <= '0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      quantum0_r  <= quantum0_nxt;
      quantum1_r  <= quantum1_nxt;
      quantum2_r  <= quantum2_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      running_r   <= running_nxt;
      cpu_busy_r  <= cpu_busy_nxt;
      req_pend_r  <= req_pend_nxt;
      slice_r     <= slice_nxt;
      time_r      <= time_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  // A tick is never answered in the cycle straight after it is taken.
  `MLFQ_ASSERT_NEXT(a_tick_holds_busy, start && !busy && (in_data.opcode == OP_TICK), busy && !out_valid, "tick transaction did not hold busy")

  // A tick report is shown only once the sequencer has returned to idle.
  `MLFQ_ASSERT_NOW(a_tick_result_idle, out_valid && (out_data.result_kind == KIND_TICK), !busy, "tick result shown while still busy")

  // A finished task is always the task that was served in that tick.
  `MLFQ_ASSERT_NOW(a_done_is_run, out_valid && out_data.done_valid, out_data.run_valid && (out_data.done_id == out_data.run_id), "finished task differs from served task")

  // A task cannot both hold the CPU and wait for its requeue, and no queue overfills.
  `MLFQ_ASSERT_NOW(a_state_consistent, !busy, !(cpu_busy_r && req_pend_r) && (count_r[0] <= CNT_W'(QUEUE_DEPTH)) && (count_r[1] <= CNT_W'(QUEUE_DEPTH)) && (count_r[2] <= CNT_W'(QUEUE_DEPTH)), "inconsistent scheduler state")

endmodule

### dv/testbench.sv
// Self-checking testbench for the three-level feedback queue scheduler.
// Depends on mlfq_pkg and the multilevel_feedback_queue_scheduler top level.
`timescale 1ns / 1ps

module testbench;
  import mlfq_pkg::*;

  localparam int DEPTH = QUEUE_DEPTH_DEFAULT;

  typedef enum logic [1:0] {STEP_ITEM, STEP_CFG, STEP_DRAIN} step_kind_t;

  typedef struct {
    step_kind_t         kind;
    in_item_t           item;
    logic [CFG_W-1:0]   reg_idx;
    logic [QUANT_W-1:0] reg_val;
    int unsigned        gap;
  } job_step_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               start = 1'b0;
  logic               busy;
  in_item_t           in_data = '0;
  logic               out_valid;
  out_item_t          out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CFG_W-1:0]   cfg_index = '0;
  logic [QUANT_W-1:0] cfg_data = '0;

  job_step_t   job_plan[$];
  out_item_t   pending_reports[$];
  int          in_flight;
  int unsigned mismatches;
  int unsigned items_planned;
  bit          calm;

  // Shadow scheduler state.
  logic [QUANT_W-1:0] quanta [LEVELS];
  logic [BURST_W-1:0] burst_tab [TASKS_DEFAULT];
  logic [BURST_W-1:0] served_tab [TASKS_DEFAULT];
  logic [LVL_W-1:0]   level_tab [TASKS_DEFAULT];
  logic [ID_W-1:0]    ring [LEVELS][DEPTH];
  int                 q_head [LEVELS];
  int                 q_tail [LEVELS];
  int                 q_count [LEVELS];
  logic [ID_W-1:0]    cur_task;
  bit                 cpu_on;
  bit                 requeue_due;
  logic [7:0]         slice;
  logic [TIME_W-1:0]  now_ticks;

  multilevel_feedback_queue_scheduler u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
  end

  // A full ready queue swallows the task without trace.
  function automatic void enqueue(int lv, logic [ID_W-1:0] id);
    if (q_count[lv] < DEPTH) begin
      ring[lv][q_tail[lv]] = id;
      q_tail[lv] = (q_tail[lv] + 1) % DEPTH;
      q_count[lv] = q_count[lv] + 1;
    end
  endfunction

  // Works out the report that the scheduler owes for one transaction.
  function automatic out_item_t serve_item(in_item_t it);
    out_item_t        rep;
    logic [LVL_W-1:0] lvl;
    logic [ID_W-1:0]  t;
    int               lv;
    rep = '0;
    if (it.opcode == OP_ARRIVE) begin
      rep.result_kind = KIND_ARRIVE;
      rep.now_time    = now_ticks;
      if (q_count[LVL_TOP] < DEPTH) begin
        burst_tab[it.task_id]  = it.task_burst;
        served_tab[it.task_id] = '0;
        level_tab[it.task_id]  = LVL_TOP;
        enqueue(LVL_TOP, it.task_id);
        rep.accepted = 1'b1;
      end
      return rep;
    end
    // A task preempted last tick goes back first; it only sinks a level when
    // something else is waiting.
    if (requeue_due) begin
      t   = cur_task;
      lvl = level_tab[t];
      if ((q_count[0] != 0 || q_count[1] != 0 || q_count[2] != 0) && lvl != LVL_BOTTOM)
        lvl = lvl + 1'b1;
      level_tab[t] = lvl;
      enqueue(lvl, t);
      cpu_on      = 1'b0;
      requeue_due = 1'b0;
    end
    if (!cpu_on) begin
      for (lv = 0; lv < LEVELS; lv++) begin
        if (!cpu_on && q_count[lv] != 0) begin
          cur_task   = ring[lv][q_head[lv]];
          q_head[lv] = (q_head[lv] + 1) % DEPTH;
          q_count[lv] = q_count[lv] - 1;
          cpu_on     = 1'b1;
          slice      = '0;
        end
      end
    end
    now_ticks       = now_ticks + 1'b1;
    rep.result_kind = KIND_TICK;
    rep.now_time    = now_ticks;
    if (cpu_on) begin
      t   = cur_task;
      lvl = level_tab[t];
      if (served_tab[t] != 8'hFF) served_tab[t] = served_tab[t] + 1'b1;
      if (slice != 8'hFF) slice = slice + 1'b1;
      rep.run_valid = 1'b1;
      rep.run_id    = t;
      if (served_tab[t] >= burst_tab[t]) begin
        cpu_on         = 1'b0;
        rep.done_valid = 1'b1;
        rep.done_id    = t;
      end else if (slice >= quanta[lvl]) begin
        requeue_due = 1'b1;
        cpu_on      = 1'b0;
      end
    end
    return rep;
  endfunction

  // Driver: presents planned transactions, holds configuration writes and
  // drain points until every owed report has come back.
  always @(posedge clk) begin : driver
    logic start_nx;
    logic cfg_nx;
    bit   settled;
    if (!rst_n) begin
      start     <= 1'b0;
      cfg_valid <= 1'b0;
      in_data   <= '0;
      cfg_index <= '0;
      cfg_data  <= '0;
      in_flight = 0;
      quanta[0] = QUANTUM0_RESET;
      quanta[1] = QUANTUM1_RESET;
      quanta[2] = QUANTUM2_RESET;
      for (int lv = 0; lv < LEVELS; lv++) begin
        q_head[lv]  = 0;
        q_tail[lv]  = 0;
        q_count[lv] = 0;
      end
      cur_task    = '0;
      cpu_on      = 1'b0;
      requeue_due = 1'b0;
      slice       = '0;
      now_ticks   = '0;
    end else begin
      start_nx = start;
      cfg_nx   = cfg_valid;
      if (start && !busy) begin
        pending_reports.push_back(serve_item(in_data));
        in_flight = in_flight + 1;
        start_nx  = 1'b0;
      end
      if (out_valid) in_flight = in_flight - 1;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_QUANTUM0: quanta[0] = cfg_data;
          CFG_QUANTUM1: quanta[1] = cfg_data;
          CFG_QUANTUM2: quanta[2] = cfg_data;
          default: ;
        endcase
        cfg_nx = 1'b0;
      end
      settled = !start_nx && !cfg_nx && in_flight == 0;
      if (!start_nx && !cfg_nx && job_plan.size() != 0) begin
        case (job_plan[0].kind)
          STEP_ITEM: begin
            if (job_plan[0].gap != 0) begin
              job_plan[0].gap = job_plan[0].gap - 1;
            end else begin
              in_data  <= job_plan[0].item;
              start_nx = 1'b1;
              void'(job_plan.pop_front());
            end
          end
          STEP_CFG: begin
            if (settled) begin
              cfg_index <= job_plan[0].reg_idx;
              cfg_data  <= job_plan[0].reg_val;
              cfg_nx    = 1'b1;
              void'(job_plan.pop_front());
            end
          end
          default: begin
            if (settled) void'(job_plan.pop_front());
          end
        endcase
      end
      start     <= start_nx;
      cfg_valid <= cfg_nx;
    end
  end

  task automatic check_field(string name, logic [TIME_W-1:0] want, logic [TIME_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Monitor: every report is matched against the oldest one owed.
  always @(posedge clk) begin : monitor
    out_item_t want;
    if (rst_n && out_valid) begin
      if (pending_reports.size() == 0) begin
        $error("report with no transaction outstanding: %h", out_data);
        mismatches++;
      end else begin
        want = pending_reports.pop_front();
        check_field("result_kind", want.result_kind, out_data.result_kind);
        check_field("accepted", want.accepted, out_data.accepted);
        check_field("run_valid", want.run_valid, out_data.run_valid);
        check_field("run_id", want.run_id, out_data.run_id);
        check_field("now_time", want.now_time, out_data.now_time);
        check_field("done_valid", want.done_valid, out_data.done_valid);
        check_field("done_id", want.done_id, out_data.done_id);
      end
    end
  end

  function automatic int unsigned next_gap();
    return calm ? 0 : $urandom_range(0, 6);
  endfunction

  task automatic add_arrive(logic [ID_W-1:0] id, logic [BURST_W-1:0] burst);
    job_step_t s;
    s.kind = STEP_ITEM;
    s.item.opcode     = OP_ARRIVE;
    s.item.task_id    = id;
    s.item.task_burst = burst;
    s.reg_idx = '0;
    s.reg_val = '0;
    s.gap     = next_gap();
    job_plan.push_back(s);
    items_planned++;
  endtask

  // Tick transactions carry random id and burst bits, which must be ignored.
  task automatic add_ticks(int unsigned n);
    job_step_t s;
    repeat (n) begin
      s.kind = STEP_ITEM;
      s.item.opcode     = OP_TICK;
      s.item.task_id    = ID_W'($urandom);
      s.item.task_burst = BURST_W'($urandom);
      s.reg_idx = '0;
      s.reg_val = '0;
      s.gap     = next_gap();
      job_plan.push_back(s);
      items_planned++;
    end
  endtask

  task automatic add_drain();
    job_step_t s;
    s.kind = STEP_DRAIN;
    s.item = '0;
    s.reg_idx = '0;
    s.reg_val = '0;
    s.gap     = 0;
    job_plan.push_back(s);
  endtask

  task automatic add_quanta(logic [QUANT_W-1:0] q0, logic [QUANT_W-1:0] q1,
                            logic [QUANT_W-1:0] q2);
    job_step_t s;
    s.kind = STEP_CFG;
    s.item = '0;
    s.gap  = 0;
    s.reg_idx = CFG_QUANTUM0; s.reg_val = q0; job_plan.push_back(s);
    s.reg_idx = CFG_QUANTUM1; s.reg_val = q1; job_plan.push_back(s);
    s.reg_idx = CFG_QUANTUM2; s.reg_val = q2; job_plan.push_back(s);
  endtask

  function automatic logic [QUANT_W-1:0] pick_quantum();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 5) return 8'd1;
    if (r < 7) return 8'd255;
    if (r < 17) return QUANT_W'($urandom_range(1, 8));
    return QUANT_W'($urandom_range(1, 255));
  endfunction

  // Mostly short bursts so that tasks finish and queues turn over.
  function automatic logic [BURST_W-1:0] pick_burst();
    int unsigned r;
    r = $urandom_range(0, 49);
    if (r < 34) return BURST_W'($urandom_range(1, 6));
    if (r < 44) return BURST_W'($urandom_range(1, 255));
    if (r < 46) return 8'd255;
    if (r < 48) return 8'd1;
    return 8'd0;
  endfunction

  task automatic random_phase(int unsigned quota);
    int unsigned first;
    int unsigned pick;
    first = items_planned;
    add_quanta(pick_quantum(), pick_quantum(), pick_quantum());
    while (items_planned - first < quota) begin
      calm = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        // Fill the top queue to or past its depth, then tick it down so that the
        // lower queues fill and requeues can fall off a full queue.
        repeat ($urandom_range(16, 18)) add_arrive(ID_W'($urandom), pick_burst());
        add_ticks($urandom_range(18, 30));
      end else if (pick <= 6) begin
        repeat ($urandom_range(1, 4)) add_arrive(ID_W'($urandom), pick_burst());
        add_ticks($urandom_range(1, 12));
      end else if (pick == 7) begin
        add_ticks($urandom_range(1, 6));
      end else if (pick == 8) begin
        add_drain();
        add_arrive(ID_W'($urandom), pick_burst());
        add_ticks($urandom_range(1, 4));
      end else begin
        repeat ($urandom_range(2, 6)) add_arrive(ID_W'($urandom), pick_burst());
      end
    end
  endtask

  initial begin : stimulus
    int unsigned ph;
    mismatches    = 0;
    items_planned = 0;

    // Directed part under the reset quanta: an idle tick, a zero burst that
    // finishes on its first tick, demotion, no demotion when nothing else
    // waits, and a re-arrival of a task that is still running.
    calm = 1'b1;
    add_ticks(1);
    add_arrive(4'd0, 8'd3);
    add_arrive(4'd15, 8'd255);
    add_arrive(4'd5, 8'd0);
    add_ticks(6);
    calm = 1'b0;
    add_arrive(4'd15, 8'd2);
    add_ticks(4);
    // A zero quantum preempts after one tick; the widest quanta only after 255 ticks.
    add_quanta(8'd0, 8'd255, 8'd255);
    add_arrive(4'd10, 8'd1);
    add_arrive(4'd7, 8'd4);
    add_ticks(4);
    add_quanta(8'd255, 8'd1, 8'd1);
    calm = 1'b1;
    add_arrive(4'd9, 8'd255);
    add_arrive(4'd6, 8'd2);
    add_ticks(3);

    for (ph = 0; ph < 10; ph++) begin
      random_phase(100);
    end

    while (job_plan.size() != 0 || start || cfg_valid || in_flight != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
    if (pending_reports.size() != 0) begin
      $error("%0d reports never arrived", pending_reports.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("multilevel_feedback_queue_scheduler test passed");
    end else begin
      $display("multilevel_feedback_queue_scheduler test failed");
    end
    $finish;
  end

  initial begin : watchdog
    #40ms;
    $display("multilevel_feedback_queue_scheduler test failed");
    $finish;
  end

endmodule

### multilevel_feedback_queue_scheduler.f
+incdir+design
design/mlfq_pkg.sv
design/mlfq_alu.sv
design/mlfq_task_table.sv
design/mlfq_queue_ram.sv
design/multilevel_feedback_queue_scheduler.sv
dv/testbench.sv
